/* hdl/sar_seq_pkg.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer package
// Shared types, codes and helper functions of the SAR ADC sequencer.
// ---------------------------------------------------------------------------
package sar_seq_pkg;

   localparam int TRIAL_W = 9;
   localparam int RAW_W   = 10;
   localparam int MV_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [TRIAL_W-1:0] trial_type;
   typedef logic [RAW_W-1:0]   raw_type;
   typedef logic [MV_W-1:0]    mv_type;
   typedef logic [1:0]         mode_type;

   localparam mode_type MODE_4BIT    = 2'd0;
   localparam mode_type MODE_8BIT    = 2'd1;
   localparam mode_type MODE_9BIT    = 2'd2;
   localparam mode_type MODE_INVALID = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE = 2'd2;

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_READING = 1'b1;

   localparam trial_type FIRST_TRIAL_4BIT = 9'd8;
   localparam trial_type FIRST_TRIAL_8BIT = 9'd128;
   localparam trial_type FIRST_TRIAL_9BIT = 9'd256;
   localparam trial_type EXTRA_STEP_TRIAL = 9'd15;
   localparam trial_type EXTRA_TRIAL      = 9'd16;
   localparam logic [4:0] MV_PER_LSB_4BIT = 5'd25;
   localparam mv_type MV_MAX = 16'hFFFF;

   typedef struct packed {
      trial_type trial;
      trial_type step;
      logic      last_reading;
      logic      have_reading;
      logic      converting;
   } state_type;

   typedef struct packed {
      trial_type dac_code;
      logic      dac_update;
      logic      done_res;
      raw_type   raw_value;
      logic      not_configured;
      mode_type  mode;
   } stage_type;

   function automatic trial_type final_step(input mode_type mode);
      case (mode)
         MODE_4BIT: final_step = FIRST_TRIAL_4BIT;
         MODE_8BIT: final_step = FIRST_TRIAL_8BIT;
         default:   final_step = FIRST_TRIAL_9BIT;
      endcase
   endfunction

   function automatic trial_type drive_code(input mode_type mode, input trial_type trial);
      if (mode == MODE_4BIT) begin
         drive_code = trial - 9'd1;
      end else begin
         drive_code = trial;
      end
   endfunction

   function automatic logic [3:0] bit_index(input trial_type value);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = 0; i < TRIAL_W; i++) begin
         if (value[i]) begin
            idx = 4'(i);
         end
      end
      bit_index = idx;
   endfunction

endpackage

/* hdl/sar_req_if.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer request channel
// Valid/ready channel that carries start requests and comparator readings.
// ---------------------------------------------------------------------------
interface sar_req_if;
   logic valid;
   logic ready;
   logic req_type;
   logic comparator_level;

   modport source (output valid, output req_type, output comparator_level, input ready);
   modport sink   (input valid, input req_type, input comparator_level, output ready);
endinterface

/* hdl/sar_rsp_if.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer response channel
// Valid/ready channel that carries one result per request transaction.
// ---------------------------------------------------------------------------
interface sar_rsp_if;
   logic                 valid;
   logic                 ready;
   sar_seq_pkg::trial_type dac_code;
   logic                 dac_update;
   logic                 done_res;
   sar_seq_pkg::raw_type raw_value;
   sar_seq_pkg::mv_type  millivolts;
   logic                 not_configured;

   modport source (output valid, output dac_code, output dac_update, output done_res,
                   output raw_value, output millivolts, output not_configured,
                   input ready);
   modport sink   (input valid, input dac_code, input dac_update, input done_res,
                   input raw_value, input millivolts, input not_configured,
                   output ready);
endinterface

/* hdl/sar_adc_sequencer.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer
// Successive-approximation controller for a comparator and a trial DAC.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_chan  in         request type (start or reading), comparator level
//  rsp_chan  out        DAC code and update, done, raw value, millivolts, error
//  csr_*     in         write enable, register index, write data
//
//  A request transaction can be accepted in every cycle; its response passes
//  the decision stage register, then the millivolt multiplier into the output
//  register. The conversion state updates in the accept cycle, so readings can
//  follow each other without gaps. A stalled response holds both stages, and
//  the request side stalls only when both stages are full. Reset is synchronous
//  and clears the configuration, the conversion state and the valid flags.
// ---------------------------------------------------------------------------
module sar_adc_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   sar_req_if.sink                               req_chan,
   sar_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [sar_seq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sar_seq_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   logic                   enabled_ff;
   sar_seq_pkg::mode_type  mode_ff;
   sar_seq_pkg::mv_type    reference_ff;
   sar_seq_pkg::state_type state_ff, state_in;
   sar_seq_pkg::stage_type stage_ff, stage_in;
   logic                   stage_valid_ff, stage_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   accept;
   logic                   out_load;
   sar_seq_pkg::mv_type    mv_in;
   sar_seq_pkg::mv_type    mv_ff;
   sar_seq_pkg::stage_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         mode_ff      <= sar_seq_pkg::MODE_4BIT;
         reference_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            sar_seq_pkg::CSR_ENABLED:   enabled_ff   <= csr_write_data[0];
            sar_seq_pkg::CSR_MODE:      mode_ff      <= csr_write_data[1:0];
            sar_seq_pkg::CSR_REFERENCE: reference_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign out_load       = stage_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || out_load;
   assign accept         = req_chan.valid && req_chan.ready;

   sar_seq_step u_step (
      .cur              (state_ff),
      .req_type         (req_chan.req_type),
      .comparator_level (req_chan.comparator_level),
      .enabled          (enabled_ff),
      .mode             (mode_ff),
      .nxt              (state_in),
      .res              (stage_in)
   );

   sar_seq_scale u_scale (
      .mode         (stage_ff.mode),
      .raw_value    (stage_ff.raw_value),
      .reference_mv (reference_ff),
      .millivolts   (mv_in)
   );

   always_comb begin
      stage_valid_in = accept ? 1'b1 : (out_load ? 1'b0 : stage_valid_ff);
      out_valid_in   = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '{trial: '0, step: 9'd1, last_reading: 1'b0,
                             have_reading: 1'b0, converting: 1'b0};
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
      if (out_load) begin
         out_ff <= stage_ff;
         mv_ff  <= mv_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.dac_code       = out_ff.dac_code;
   assign rsp_chan.dac_update     = out_ff.dac_update;
   assign rsp_chan.done_res       = out_ff.done_res;
   assign rsp_chan.raw_value      = out_ff.raw_value;
   assign rsp_chan.millivolts     = mv_ff;
   assign rsp_chan.not_configured = out_ff.not_configured;

endmodule

/* hdl/sar_seq_step.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer decision step
// Computes the next conversion state and the result fields for one request.
// ---------------------------------------------------------------------------
module sar_seq_step (
   input  sar_seq_pkg::state_type cur,
   input  logic                   req_type,
   input  logic                   comparator_level,
   input  logic                   enabled,
   input  sar_seq_pkg::mode_type  mode,
   output sar_seq_pkg::state_type nxt,
   output sar_seq_pkg::stage_type res
);

   logic                   ok;
   logic                   up;
   sar_seq_pkg::trial_type fin;
   sar_seq_pkg::trial_type step_base;
   sar_seq_pkg::trial_type step_next;
   sar_seq_pkg::trial_type delta;
   sar_seq_pkg::trial_type first_trial;

   assign ok  = enabled && (mode != sar_seq_pkg::MODE_INVALID);
   assign fin = sar_seq_pkg::final_step(mode);
   assign up  = (mode == sar_seq_pkg::MODE_4BIT) ? comparator_level : !comparator_level;

   always_comb begin
      step_base = (cur.step == '0) ? 9'd1 : cur.step;
      step_next = {step_base[7:0], 1'b0};
      if (step_next == '0) begin
         step_next = 9'd1;
      end
      delta = fin >> sar_seq_pkg::bit_index(step_next);
      case (mode)
         sar_seq_pkg::MODE_4BIT: first_trial = sar_seq_pkg::FIRST_TRIAL_4BIT;
         sar_seq_pkg::MODE_8BIT: first_trial = sar_seq_pkg::FIRST_TRIAL_8BIT;
         default:                first_trial = sar_seq_pkg::FIRST_TRIAL_9BIT;
      endcase
   end

   always_comb begin
      nxt = cur;
      res = '0;
      res.mode = mode;
      if (req_type == sar_seq_pkg::REQ_START) begin
         nxt.have_reading = 1'b0;
         if (!ok) begin
            nxt.converting     = 1'b0;
            res.done_res       = 1'b1;
            res.not_configured = 1'b1;
         end else begin
            nxt.converting = 1'b1;
            nxt.step       = 9'd1;
            nxt.trial      = first_trial;
            res.dac_code   = sar_seq_pkg::drive_code(mode, first_trial);
            res.dac_update = 1'b1;
         end
      end else if (cur.converting) begin
         if (!ok) begin
            nxt.converting     = 1'b0;
            nxt.have_reading   = 1'b0;
            res.done_res       = 1'b1;
            res.not_configured = 1'b1;
         end else if (!cur.have_reading || (cur.last_reading != comparator_level)) begin
            nxt.last_reading = comparator_level;
            nxt.have_reading = 1'b1;
         end else begin
            nxt.have_reading = 1'b0;
            if (cur.step >= fin) begin
               if ((mode == sar_seq_pkg::MODE_4BIT) && comparator_level &&
                   (cur.trial == sar_seq_pkg::EXTRA_STEP_TRIAL)) begin
                  nxt.trial      = sar_seq_pkg::EXTRA_TRIAL;
                  res.dac_code   = sar_seq_pkg::drive_code(mode, sar_seq_pkg::EXTRA_TRIAL);
                  res.dac_update = 1'b1;
               end else begin
                  res.raw_value  = up ? ({cur.trial, 1'b0} + 10'd1) : ({cur.trial, 1'b0} - 10'd1);
                  res.done_res   = 1'b1;
                  nxt.converting = 1'b0;
               end
            end else begin
               nxt.step       = step_next;
               nxt.trial      = up ? (cur.trial + delta) : (cur.trial - delta);
               res.dac_code   = sar_seq_pkg::drive_code(mode, nxt.trial);
               res.dac_update = 1'b1;
            end
         end
      end
   end

endmodule

/* hdl/sar_seq_scale.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer millivolt scaling
// Converts a raw conversion value to millivolts with saturation.
// ---------------------------------------------------------------------------
module sar_seq_scale (
   input  sar_seq_pkg::mode_type mode,
   input  sar_seq_pkg::raw_type  raw_value,
   input  sar_seq_pkg::mv_type   reference_mv,
   output sar_seq_pkg::mv_type   millivolts
);

   logic [25:0] product;
   logic [16:0] scaled;

   always_comb begin
      if (mode == sar_seq_pkg::MODE_4BIT) begin
         product = 26'(raw_value) * 26'(sar_seq_pkg::MV_PER_LSB_4BIT);
         scaled  = product[16:0];
      end else begin
         product = 26'(raw_value) * 26'(reference_mv);
         if (mode == sar_seq_pkg::MODE_8BIT) begin
            scaled = product[25:9];
         end else begin
            scaled = {1'b0, product[25:10]};
         end
      end
      millivolts = scaled[16] ? sar_seq_pkg::MV_MAX : scaled[15:0];
   end

endmodule

/* hdl/sar_seq_checker.sv */
// ---------------------------------------------------------------------------
// SAR ADC sequencer checker
// Port-level assertions on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
module sar_seq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   dac_update,
   input logic                   done_res,
   input sar_seq_pkg::raw_type   raw_value,
   input sar_seq_pkg::mv_type    millivolts,
   input logic                   not_configured
);

   // A stalled response transaction keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(raw_value) && $stable(millivolts))
      else $error("stalled response changed");

   // A rejected conversion reports done with zero data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && not_configured |-> done_res && (raw_value == '0) && (millivolts == '0))
      else $error("rejected conversion carries data");

   // A new DAC trial and a finished conversion never share a response.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dac_update |-> !done_res && (raw_value == '0))
      else $error("DAC update on a finished conversion");

   // Result data appears only with done.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !done_res |-> (raw_value == '0) && (millivolts == '0))
      else $error("result data without done");

   // No response is offered right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind sar_adc_sequencer sar_seq_checker u_sar_seq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .dac_update     (rsp_chan.dac_update),
   .done_res       (rsp_chan.done_res),
   .raw_value      (rsp_chan.raw_value),
   .millivolts     (rsp_chan.millivolts),
   .not_configured (rsp_chan.not_configured)
);
